>>> src/stcc_pkg.sv
`default_nettype none
package stcc_pkg;

    localparam int FIELD_W = 10;
    localparam int DEF_MAX_NODES = 1024;
    localparam int DEF_MAX_EDGES = 4096;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_BLUE = 1'd1;

    typedef struct packed {
        logic               is_blue;
        logic [FIELD_W-1:0] end_a;
        logic [FIELD_W-1:0] end_b;
    } edge_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_FETCH,
        ST_EDGE,
        ST_FIND_A,
        ST_FIND_B,
        ST_PASS_END,
        ST_DONE
    } state_t;

endpackage
`default_nettype wire

>>> src/stcc_if.sv
`default_nettype none
interface stcc_edge_if;
    logic                        valid;
    logic                        ready;
    logic                        is_blue;
    logic [stcc_pkg::FIELD_W-1:0] end_a;
    logic [stcc_pkg::FIELD_W-1:0] end_b;
    logic                        last_edge;

    modport source (output valid, is_blue, end_a, end_b, last_edge, input ready);
    modport sink (input valid, is_blue, end_a, end_b, last_edge, output ready);
endinterface

interface stcc_result_if;
    logic                        valid;
    logic                        ready;
    logic                        feasible;
    logic [stcc_pkg::FIELD_W-1:0] fewest_blue;
    logic [stcc_pkg::FIELD_W-1:0] most_blue;

    modport source (output valid, feasible, fewest_blue, most_blue, input ready);
    modport sink (input valid, feasible, fewest_blue, most_blue, output ready);
endinterface
`default_nettype wire

>>> src/spanning_tree_color_count_range.sv
// edge load: one transfer per cycle, ready whenever no run is in progress
// run after the last edge: two passes, each a sweep that resets all MAX_NODES
// parent table entries, then two rounds over the stored edges (the pass ends early
// once the union limit is reached), each edge fetched from edge memory and, for an
// edge of the colour in turn, both roots chased by parent table reads; one parent table read per cycle bounds the run
// async active-low reset clears control and the edge, union and tally counts, and sets
// config to one node, target 0; result registers and memories are not reset
`default_nettype none
module spanning_tree_color_count_range #(
    parameter int MAX_NODES = stcc_pkg::DEF_MAX_NODES,
    parameter int MAX_EDGES = stcc_pkg::DEF_MAX_EDGES
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [stcc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [stcc_pkg::FIELD_W-1:0]   cfg_data,
    stcc_edge_if.sink                           in_ch,
    stcc_result_if.source                       out_ch
);

    localparam int NW = $clog2(MAX_NODES);
    localparam int EW = $clog2(MAX_EDGES);
    localparam int TW = EW + 1;
    localparam int FW = stcc_pkg::FIELD_W;

    stcc_pkg::state_t state_reg, state_next;

    logic [FW-1:0] node_count_reg, target_blue_reg;
    logic [TW-1:0] edge_total_reg, edge_total_next;
    logic [TW-1:0] idx_reg, idx_next;
    logic [NW-1:0] clr_reg, clr_next;
    logic [NW-1:0] ra_reg, ra_next, rb_reg, rb_next;
    logic [FW-1:0] union_reg, union_next, tally_reg, tally_next;
    logic [FW-1:0] most_reg, most_next, fewest_reg, fewest_next;
    logic          pass_reg, pass_next, round_reg, round_next;
    logic          out_valid_reg, out_valid_next, feasible_reg, feasible_next;

    stcc_pkg::edge_t edge_mem [MAX_EDGES];
    stcc_pkg::edge_t edge_rd_reg, edge_wdata;
    logic            edge_we;
    logic [EW-1:0]   edge_waddr, edge_raddr;

    logic [NW-1:0] par_mem [MAX_NODES];
    logic [NW-1:0] par_rd_reg, par_raddr, par_waddr, par_wdata;
    logic          par_we;

    logic in_xfer, limited, limit_hit, colour, in_ok;

    assign in_xfer   = in_ch.valid && in_ch.ready;
    assign limited   = node_count_reg != '0;
    assign limit_hit = limited && (union_reg == node_count_reg - FW'(1));
    assign colour    = ~(pass_reg ^ round_reg);
    assign in_ok     = (32'(in_ch.end_a) < 32'(MAX_NODES)) &&
                       (32'(in_ch.end_b) < 32'(MAX_NODES)) &&
                       (32'(edge_total_reg) < 32'(MAX_EDGES));

    assign in_ch.ready        = state_reg == stcc_pkg::ST_IDLE;
    assign out_ch.valid       = out_valid_reg;
    assign out_ch.feasible    = feasible_reg;
    assign out_ch.fewest_blue = fewest_reg;
    assign out_ch.most_blue   = most_reg;

    always_ff @(posedge clk)
    begin
        if (edge_we)
        begin
            edge_mem[edge_waddr] <= edge_wdata;
        end
        edge_rd_reg <= edge_mem[edge_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (par_we)
        begin
            par_mem[par_waddr] <= par_wdata;
        end
        par_rd_reg <= par_mem[par_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg  <= FW'(1);
            target_blue_reg <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == stcc_pkg::CFG_NODE_COUNT)
            begin
                node_count_reg <= cfg_data;
            end
            if (cfg_index == stcc_pkg::CFG_TARGET_BLUE)
            begin
                target_blue_reg <= cfg_data;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            stcc_pkg::ST_IDLE:
            begin
                if (in_xfer && in_ch.last_edge)
                begin
                    state_next = stcc_pkg::ST_CLEAR;
                end
            end
            stcc_pkg::ST_CLEAR:
            begin
                if (clr_reg == NW'(MAX_NODES - 1))
                begin
                    state_next = stcc_pkg::ST_FETCH;
                end
            end
            stcc_pkg::ST_FETCH:
            begin
                if (limit_hit || (idx_reg == edge_total_reg && round_reg))
                begin
                    state_next = stcc_pkg::ST_PASS_END;
                end
                else if (idx_reg != edge_total_reg)
                begin
                    state_next = stcc_pkg::ST_EDGE;
                end
            end
            stcc_pkg::ST_EDGE:
            begin
                state_next = (edge_rd_reg.is_blue == colour) ? stcc_pkg::ST_FIND_A
                                                             : stcc_pkg::ST_FETCH;
            end
            stcc_pkg::ST_FIND_A:
            begin
                if (par_rd_reg == ra_reg)
                begin
                    state_next = stcc_pkg::ST_FIND_B;
                end
            end
            stcc_pkg::ST_FIND_B:
            begin
                if (par_rd_reg == rb_reg)
                begin
                    state_next = stcc_pkg::ST_FETCH;
                end
            end
            stcc_pkg::ST_PASS_END:
            begin
                state_next = pass_reg ? stcc_pkg::ST_DONE : stcc_pkg::ST_CLEAR;
            end
            stcc_pkg::ST_DONE:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    state_next = stcc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = stcc_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        edge_total_next = edge_total_reg;
        idx_next        = idx_reg;
        clr_next        = clr_reg;
        ra_next         = ra_reg;
        rb_next         = rb_reg;
        union_next      = union_reg;
        tally_next      = tally_reg;
        most_next       = most_reg;
        fewest_next     = fewest_reg;
        pass_next       = pass_reg;
        round_next      = round_reg;
        feasible_next   = feasible_reg;
        out_valid_next  = out_valid_reg && !out_ch.ready;
        edge_we         = 1'b0;
        edge_waddr      = edge_total_reg[EW-1:0];
        edge_wdata      = '{is_blue: in_ch.is_blue, end_a: in_ch.end_a, end_b: in_ch.end_b};
        edge_raddr      = idx_reg[EW-1:0];
        par_we          = 1'b0;
        par_waddr       = clr_reg;
        par_wdata       = clr_reg;
        par_raddr       = ra_reg;
        case (state_reg)
            stcc_pkg::ST_IDLE:
            begin
                if (in_xfer)
                begin
                    if (in_ok)
                    begin
                        edge_we         = 1'b1;
                        edge_total_next = edge_total_reg + TW'(1);
                    end
                    pass_next = 1'b0;
                    clr_next  = '0;
                end
            end
            stcc_pkg::ST_CLEAR:
            begin
                par_we     = 1'b1;
                clr_next   = clr_reg + NW'(1);
                idx_next   = '0;
                round_next = 1'b0;
                union_next = '0;
                tally_next = '0;
            end
            stcc_pkg::ST_FETCH:
            begin
                if (!limit_hit && idx_reg == edge_total_reg && !round_reg)
                begin
                    round_next = 1'b1;
                    idx_next   = '0;
                end
            end
            stcc_pkg::ST_EDGE:
            begin
                if (edge_rd_reg.is_blue == colour)
                begin
                    ra_next   = NW'(edge_rd_reg.end_a);
                    rb_next   = NW'(edge_rd_reg.end_b);
                    par_raddr = NW'(edge_rd_reg.end_a);
                end
                else
                begin
                    idx_next = idx_reg + TW'(1);
                end
            end
            stcc_pkg::ST_FIND_A:
            begin
                if (par_rd_reg == ra_reg)
                begin
                    par_raddr = rb_reg;
                end
                else
                begin
                    ra_next   = par_rd_reg;
                    par_raddr = par_rd_reg;
                end
            end
            stcc_pkg::ST_FIND_B:
            begin
                if (par_rd_reg == rb_reg)
                begin
                    idx_next = idx_reg + TW'(1);
                    if (ra_reg != rb_reg)
                    begin
                        par_we     = 1'b1;
                        par_waddr  = rb_reg;
                        par_wdata  = ra_reg;
                        union_next = union_reg + FW'(1);
                        tally_next = tally_reg + FW'(colour);
                    end
                end
                else
                begin
                    rb_next   = par_rd_reg;
                    par_raddr = par_rd_reg;
                end
            end
            stcc_pkg::ST_PASS_END:
            begin
                if (pass_reg)
                begin
                    fewest_next = tally_reg;
                end
                else
                begin
                    most_next = tally_reg;
                    pass_next = 1'b1;
                    clr_next  = '0;
                end
            end
            stcc_pkg::ST_DONE:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_valid_next  = 1'b1;
                    feasible_next   = (fewest_reg <= target_blue_reg) &&
                                      (target_blue_reg <= most_reg);
                    edge_total_next = '0;
                end
            end
            default:
            begin
                out_valid_next = out_valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= stcc_pkg::ST_IDLE;
            edge_total_reg <= '0;
            idx_reg        <= '0;
            clr_reg        <= '0;
            union_reg      <= '0;
            tally_reg      <= '0;
            pass_reg       <= 1'b0;
            round_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            edge_total_reg <= edge_total_next;
            idx_reg        <= idx_next;
            clr_reg        <= clr_next;
            union_reg      <= union_next;
            tally_reg      <= tally_next;
            pass_reg       <= pass_next;
            round_reg      <= round_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ra_reg       <= ra_next;
        rb_reg       <= rb_next;
        most_reg     <= most_next;
        fewest_reg   <= fewest_next;
        feasible_reg <= feasible_next;
    end

    a_limit_ends_pass: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == stcc_pkg::ST_FETCH && limit_hit) |=> state_reg == stcc_pkg::ST_PASS_END)
        else $error("union limit did not end the pass");

    a_edge_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(edge_total_reg) <= 32'(MAX_EDGES))
        else $error("edge count beyond store depth");

    a_union_distinct: assert property (@(posedge clk) disable iff (!rst_n)
        (par_we && state_reg == stcc_pkg::ST_FIND_B) |-> par_waddr != par_wdata)
        else $error("union of a root with itself");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == stcc_pkg::ST_DONE)
        else $error("result raised outside the done state");

endmodule
`default_nettype wire

>>> test/testbench.sv
`default_nettype none
class blue_range_board;
    logic [9:0]  node_count = 10'd1;
    logic [9:0]  target_blue = 10'd0;
    logic [20:0] stored_edges[$];
    logic [9:0]  parent[1024];
    logic [20:0] awaited[$];
    int          errors = 0;

    function logic [9:0] root_of(logic [9:0] n);
        logic [9:0] r;
        r = n;
        while (parent[r] != r)
            r = parent[r];
        return r;
    endfunction

    function logic [9:0] kruskal_blue(logic first);
        logic [9:0] limit;
        logic [9:0] unions;
        logic [9:0] blues;
        logic [9:0] ra;
        logic [9:0] rb;
        logic       colour;
        limit = node_count - 10'd1;
        unions = '0;
        blues = '0;
        for (int i = 0; i < 1024; i++)
            parent[i] = i[9:0];
        for (int round = 0; round < 2; round++)
        begin
            colour = (round == 0) ? first : !first;
            foreach (stored_edges[i])
            begin
                if (node_count != 0 && unions == limit)
                    return blues;
                if (stored_edges[i][20] != colour)
                    continue;
                ra = root_of(stored_edges[i][19:10]);
                rb = root_of(stored_edges[i][9:0]);
                if (ra != rb)
                begin
                    parent[rb] = ra;
                    unions = unions + 10'd1;
                    blues = blues + {9'd0, colour};
                end
            end
        end
        return blues;
    endfunction

    function void note_edge(logic blue, logic [9:0] a, logic [9:0] b, logic last);
        logic [9:0] most;
        logic [9:0] fewest;
        if (stored_edges.size() < 4096)
            stored_edges.insert(stored_edges.size(), {blue, a, b});
        if (last)
        begin
            most = kruskal_blue(1'b1);
            fewest = kruskal_blue(1'b0);
            stored_edges.delete();
            awaited.insert(awaited.size(),
                           {(fewest <= target_blue && target_blue <= most) ? 1'b1 : 1'b0,
                            fewest, most});
        end
    endfunction

    function void check(logic feasible, logic [9:0] fewest, logic [9:0] most);
        logic [20:0] want;
        if (awaited.size() == 0)
        begin
            $error("result with nothing awaited");
            errors++;
            return;
        end
        want = awaited.pop_front();
        if (feasible !== want[20])
        begin
            $error("feasible: expected %0d actual %0d", want[20], feasible);
            errors++;
        end
        if (fewest !== want[19:10])
        begin
            $error("fewest_blue: expected %0d actual %0d", want[19:10], fewest);
            errors++;
        end
        if (most !== want[9:0])
        begin
            $error("most_blue: expected %0d actual %0d", want[9:0], most);
            errors++;
        end
    endfunction
endclass

module testbench;

    localparam int LIMIT = 3000000;

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           cfg_we;
    logic [stcc_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [stcc_pkg::FIELD_W-1:0]   cfg_data;
    logic                           calm = 1'b0;
    int                             cycles = 0;
    blue_range_board                board = new();

    stcc_edge_if   in_ch();
    stcc_result_if out_ch();

    spanning_tree_color_count_range dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_ch(in_ch),
        .out_ch(out_ch)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("testbench: errors");
            $finish;
        end
    end

    // transfer monitors
    always @(posedge clk)
    begin
        if (rst_n && in_ch.valid && in_ch.ready)
            board.note_edge(in_ch.is_blue, in_ch.end_a, in_ch.end_b, in_ch.last_edge);
        if (rst_n && out_ch.valid && out_ch.ready)
            board.check(out_ch.feasible, out_ch.fewest_blue, out_ch.most_blue);
    end

    always @(posedge clk)
        out_ch.ready <= calm ? 1'b1 : ($urandom_range(99) >= 37);

    task automatic send_edge(logic blue, logic [9:0] a, logic [9:0] b, logic last);
        while (!calm && $urandom_range(99) < 37)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.is_blue <= blue;
        in_ch.end_a <= a;
        in_ch.end_b <= b;
        in_ch.last_edge <= last;
        do
            @(posedge clk);
        while (!in_ch.ready);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (board.awaited.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic set_config(logic [9:0] nodes, logic [9:0] target);
        cfg_we <= 1'b1;
        cfg_index <= stcc_pkg::CFG_NODE_COUNT;
        cfg_data <= nodes;
        @(posedge clk);
        cfg_index <= stcc_pkg::CFG_TARGET_BLUE;
        cfg_data <= target;
        @(posedge clk);
        cfg_we <= 1'b0;
        board.node_count = nodes;
        board.target_blue = target;
    endtask

    task automatic random_graph(int edges, int span);
        logic [9:0] a;
        logic [9:0] b;
        for (int i = 0; i < edges; i++)
        begin
            a = 10'($urandom_range(span, 1));
            b = 10'($urandom_range(span, 1));
            case ($urandom_range(19))
                0: a = 10'd0;
                1: b = 10'd1023;
                2: b = a;
                3: a = 10'($urandom_range(1023));
                default: ;
            endcase
            send_edge(1'($urandom_range(1)), a, b, i == edges - 1);
        end
        drain();
    endtask

    initial
    begin
        int nodes;
        int span;
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= stcc_pkg::CFG_NODE_COUNT;
        cfg_data <= '0;
        in_ch.valid <= 1'b0;
        in_ch.is_blue <= 1'b0;
        in_ch.end_a <= '0;
        in_ch.end_b <= '0;
        in_ch.last_edge <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset config: single node, no unions allowed
        send_edge(1'b1, 10'd0, 10'd1023, 1'b0);
        send_edge(1'b0, 10'd1023, 10'd0, 1'b0);
        send_edge(1'b1, 10'd1, 10'd1, 1'b1);
        drain();
        set_config(10'd3, 10'd1);
        send_edge(1'b1, 10'd1, 10'd2, 1'b0);
        send_edge(1'b0, 10'd2, 10'd3, 1'b0);
        send_edge(1'b1, 10'd1, 10'd3, 1'b0);
        send_edge(1'b0, 10'd1, 10'd2, 1'b1);
        drain();
        set_config(10'd0, 10'd1022);
        send_edge(1'b0, 10'd0, 10'd1023, 1'b0);
        send_edge(1'b1, 10'd1023, 10'd512, 1'b0);
        send_edge(1'b1, 10'd341, 10'd682, 1'b0);
        send_edge(1'b0, 10'd682, 10'd0, 1'b1);
        drain();
        set_config(10'd1023, 10'd0);
        send_edge(1'b1, 10'd1022, 10'd1021, 1'b1);
        drain();
        set_config(10'd4, 10'd2);
        send_edge(1'b1, 10'd1, 10'd2, 1'b0);
        send_edge(1'b1, 10'd2, 10'd3, 1'b0);
        send_edge(1'b0, 10'd3, 10'd4, 1'b0);
        send_edge(1'b0, 10'd4, 10'd1, 1'b0);
        send_edge(1'b1, 10'd1, 10'd3, 1'b0);
        send_edge(1'b0, 10'd2, 10'd4, 1'b1);
        drain();

        for (int g = 0; g < 64; g++)
        begin
            calm = (g >= 24 && g < 34);
            if (g % 4 == 0)
            begin
                case ($urandom_range(5))
                    0: nodes = 0;
                    1: nodes = 1;
                    2: nodes = 1023;
                    default: nodes = $urandom_range(24, 2);
                endcase
                set_config(10'(nodes), 10'(($urandom_range(7) == 0) ? 1022 :
                           $urandom_range((nodes > 1 && nodes < 30) ? nodes : 12)));
            end
            span = (nodes > 1 && nodes < 30) ? nodes : $urandom_range(24, 6);
            random_graph($urandom_range(22, 1), span);
        end

        if (board.errors == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end
endmodule
`default_nettype wire
